@@ rtl/bsa_pkg.sv @@
`timescale 1ns / 1ps

package bsa_pkg;

    // Pool geometry
    localparam int MAX_ORDER = 10;
    localparam int TOP_RESET = 10;

    // Item field widths
    localparam int ORD_W = 4;
    localparam int SEG_W = 10;
    localparam int STATUS_W = 2;
    localparam int IN_TDATA_W = ((ORD_W + SEG_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SEG_W + 7) / 8) * 8;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_TOP_ORDER = 1'b0;

    // Free-map storage: one 32-bit word holds 32 block flags of one order
    localparam int WORD_LOG = 5;
    localparam int WORD_W = 1 << WORD_LOG;
    localparam int OW = ($clog2(MAX_ORDER + 1) > ORD_W) ? $clog2(MAX_ORDER + 1) : ORD_W;
    localparam int IDX_W = (MAX_ORDER > WORD_LOG) ? MAX_ORDER : WORD_LOG;
    localparam int WW = (IDX_W - WORD_LOG > 1) ? IDX_W - WORD_LOG : 1;
    localparam int CW = IDX_W + 1;
    localparam int SPAN_W = (IDX_W > SEG_W) ? IDX_W : SEG_W;
    // Orders below P_MULTI span 2^(P_MULTI-1-o) words, the rest one word each
    localparam int P_MULTI = MAX_ORDER - WORD_LOG + 1;
    localparam int N_WORDS = (P_MULTI > 0) ? (1 << P_MULTI) - 1 + (MAX_ORDER + 1 - P_MULTI)
                                           : MAX_ORDER + 1;
    localparam int AW = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;

    typedef logic [OW-1:0] t_ord;
    typedef logic [AW-1:0] t_waddr;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [WORD_LOG-1:0] t_bit;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [WW-1:0] t_woff;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_act;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    // Word unit operations
    typedef enum logic [1:0] {
        U_CLR,       // clear the selected bit
        U_CLR_MATE,  // clear the buddy of the selected bit
        U_SET,       // set the selected bit
        U_ONE_MATE   // a word holding only the buddy of the selected bit
    } t_uop;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SRD,
        S_SCHK,
        S_SPLIT,
        S_FRD,
        S_FCHK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status status;
        logic [SEG_W-1:0] first;
    } t_res;

    localparam t_ord TOP_INIT = t_ord'((TOP_RESET > MAX_ORDER) ? MAX_ORDER : TOP_RESET);

    // First word of the free map of order o
    function automatic t_waddr word_base(input t_ord o);
        t_waddr base;
        if (P_MULTI > 0) begin
            if (int'(o) <= P_MULTI) begin
                base = t_waddr'((1 << P_MULTI) - ((1 << P_MULTI) >> o));
            end else begin
                base = t_waddr'((1 << P_MULTI) - 1 + int'(o) - P_MULTI);
            end
        end else begin
            base = t_waddr'(o);
        end
        return base;
    endfunction

endpackage

@@ rtl/buddy_segment_allocator_core.sv @@
`timescale 1ns / 1ps

// Buddy segment allocator with one free bitmap per order.
// Input channel s_axis: tuser = action (0 allocate, 1 free), tdata = order
// and segment. Output channel m_axis: one item per request, tuser = status
// (0 ok, 1 no free block, 2 order above top order), tdata = first segment.
// The maps sit in a 68-word x 32-bit memory behind a single word unit,
// stepped by a small sequencer; one request is worked at a time.
// Per request, a free reads and rewrites one map word per level it visits;
// an allocate reads and checks each map word scanned (orders from the
// requested one upward, up to 2^(top-o-5) words each), then writes one word
// per split level. An order above top order is answered without a map access.
// Reset, or a write of top_order over the APB port, starts a clearing pass
// over all 68 words (one word a cycle) that leaves one free block at
// top_order; no item is accepted meanwhile. A result waits in the output
// register while the receiver stalls; the next request is accepted and
// worked meanwhile and holds at its end until the register frees up.
module buddy_segment_allocator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // order[3:0], segment[13:4]
    input  logic                            s_axis_tuser,   // action[0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // first_segment[9:0]
    output logic [bsa_pkg::STATUS_W-1:0]    m_axis_tuser,   // status[1:0]
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bsa_pkg::APB_AW-1:0]      paddr,
    input  logic [bsa_pkg::APB_DW-1:0]      pwdata,
    output logic [bsa_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    bsa_pkg::t_ord r_top;
    bsa_pkg::t_ord wr_top;
    logic          cfg_wr;
    logic          res_valid;
    logic          res_take;
    bsa_pkg::t_res res;
    logic          r_mval;
    bsa_pkg::t_res r_mres;

    // Top order register; an out-of-range value saturates
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[bsa_pkg::APB_AW-1] == bsa_pkg::REG_TOP_ORDER);
    assign wr_top = (bsa_pkg::t_ord'(pwdata[bsa_pkg::ORD_W-1:0])
                     > bsa_pkg::t_ord'(bsa_pkg::MAX_ORDER))
                  ? bsa_pkg::t_ord'(bsa_pkg::MAX_ORDER)
                  : bsa_pkg::t_ord'(pwdata[bsa_pkg::ORD_W-1:0]);
    assign prdata = bsa_pkg::APB_DW'(r_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= bsa_pkg::TOP_INIT;
        end else if (cfg_wr) begin
            r_top <= wr_top;
        end
    end

    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_wr),
        .i_top       (r_top),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_order     (s_axis_tdata[bsa_pkg::ORD_W-1:0]),
        .i_segment   (s_axis_tdata[bsa_pkg::ORD_W+bsa_pkg::SEG_W-1:bsa_pkg::ORD_W]),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // Output register: load a finished result when the slot is empty or draining
    assign res_take = !r_mval || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mval <= 1'b0;
        end else if (res_valid && res_take) begin
            r_mval <= 1'b1;
        end else if (m_axis_tready) begin
            r_mval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_mres <= res;
        end
    end

    assign m_axis_tvalid = r_mval;
    assign m_axis_tuser  = r_mres.status;
    assign m_axis_tdata  = bsa_pkg::OUT_TDATA_W'(r_mres.first);

endmodule

@@ rtl/bsa_map_ram.sv @@
`timescale 1ns / 1ps

module bsa_map_ram (
    input  logic           i_clk,
    input  logic           i_we,
    input  bsa_pkg::t_waddr i_waddr,
    input  bsa_pkg::t_word  i_wdata,
    input  bsa_pkg::t_waddr i_raddr,
    output bsa_pkg::t_word  o_rdata
);

    bsa_pkg::t_word mem [bsa_pkg::N_WORDS];
    bsa_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bsa_word_unit.sv @@
`timescale 1ns / 1ps

module bsa_word_unit (
    input  bsa_pkg::t_word i_word,
    input  bsa_pkg::t_bit  i_bit,
    input  bsa_pkg::t_uop  i_op,
    output logic           o_any,
    output bsa_pkg::t_bit  o_ffs,
    output logic           o_mate,
    output bsa_pkg::t_word o_word
);

    bsa_pkg::t_bit  mate_bit;
    bsa_pkg::t_word oh_bit;
    bsa_pkg::t_word oh_mate;

    // Lowest set bit
    always_comb begin
        o_ffs = '0;
        for (int i = bsa_pkg::WORD_W - 1; i >= 0; i--) begin
            if (i_word[i]) begin
                o_ffs = bsa_pkg::t_bit'(i);
            end
        end
    end

    assign o_any    = |i_word;
    assign mate_bit = i_bit ^ bsa_pkg::t_bit'(1);
    assign oh_bit   = bsa_pkg::t_word'(1) << i_bit;
    assign oh_mate  = bsa_pkg::t_word'(1) << mate_bit;
    assign o_mate   = i_word[mate_bit];

    always_comb begin
        unique case (i_op)
            bsa_pkg::U_CLR:      o_word = i_word & ~oh_bit;
            bsa_pkg::U_CLR_MATE: o_word = i_word & ~oh_mate;
            bsa_pkg::U_SET:      o_word = i_word | oh_bit;
            bsa_pkg::U_ONE_MATE: o_word = oh_mate;
        endcase
    end

endmodule

@@ rtl/bsa_ctrl.sv @@
`timescale 1ns / 1ps

module bsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  bsa_pkg::t_ord     i_top,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_action,
    input  logic [bsa_pkg::ORD_W-1:0] i_order,
    input  logic [bsa_pkg::SEG_W-1:0] i_segment,
    output logic              o_res_valid,
    output bsa_pkg::t_res     o_res,
    input  logic              i_res_take
);

    bsa_pkg::t_state  r_state, n_state;
    bsa_pkg::t_act    r_act, n_act;
    bsa_pkg::t_ord    r_order, n_order;
    bsa_pkg::t_ord    r_o, n_o;
    bsa_pkg::t_idx    r_idx, n_idx;
    bsa_pkg::t_woff   r_woff, n_woff;
    bsa_pkg::t_status r_status, n_status;
    bsa_pkg::t_waddr  r_caddr, n_caddr;

    logic             m_we;
    bsa_pkg::t_waddr  m_waddr;
    bsa_pkg::t_word   m_wdata;
    bsa_pkg::t_waddr  m_raddr;
    bsa_pkg::t_word   m_rdata;

    bsa_pkg::t_bit    u_bit;
    bsa_pkg::t_uop    u_op;
    logic             u_any;
    bsa_pkg::t_bit    u_ffs;
    logic             u_mate;
    bsa_pkg::t_word   u_word;

    bsa_pkg::t_ord    ord_in;
    logic             in_range;
    logic [bsa_pkg::SPAN_W-1:0] free_span;
    bsa_pkg::t_idx    split_idx;
    bsa_pkg::t_waddr  srch_addr;
    bsa_pkg::t_waddr  free_addr;
    logic [bsa_pkg::CW-1:0] scan_end;
    logic [bsa_pkg::CW-1:0] map_bits;
    logic             last_word;
    logic             merge;
    logic [bsa_pkg::SPAN_W-1:0] first_span;

    bsa_map_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    bsa_word_unit u_unit (
        .i_word (m_rdata),
        .i_bit  (u_bit),
        .i_op   (u_op),
        .o_any  (u_any),
        .o_ffs  (u_ffs),
        .o_mate (u_mate),
        .o_word (u_word)
    );

    assign ord_in   = bsa_pkg::t_ord'(i_order);
    assign in_range = ord_in <= i_top;

    // Block index of a freed segment, wrapped to the map of its order
    assign free_span = (bsa_pkg::SPAN_W'(i_segment) >> ord_in)
                     & ((bsa_pkg::SPAN_W'(1) << (i_top - ord_in)) - bsa_pkg::SPAN_W'(1));

    assign split_idx = {r_idx[bsa_pkg::IDX_W-2:0], 1'b0};
    assign srch_addr = bsa_pkg::word_base(r_o) + bsa_pkg::t_waddr'(r_woff);
    assign free_addr = bsa_pkg::word_base(r_o)
                     + bsa_pkg::t_waddr'(r_idx >> bsa_pkg::WORD_LOG);

    // Last word of the map in use at this order
    assign scan_end  = (bsa_pkg::CW'(r_woff) + bsa_pkg::CW'(1)) << bsa_pkg::WORD_LOG;
    assign map_bits  = bsa_pkg::CW'(1) << (i_top - r_o);
    assign last_word = scan_end >= map_bits;

    assign merge      = (r_o < i_top) && u_mate;
    assign first_span = bsa_pkg::SPAN_W'(r_idx) << r_order;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsa_pkg::S_CLEAR: begin
                if (r_caddr == bsa_pkg::t_waddr'(bsa_pkg::N_WORDS - 1)) begin
                    n_state = bsa_pkg::S_IDLE;
                end
            end
            bsa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (!in_range) begin
                        n_state = bsa_pkg::S_DONE;
                    end else if (i_action == bsa_pkg::ACT_FREE) begin
                        n_state = bsa_pkg::S_FRD;
                    end else begin
                        n_state = bsa_pkg::S_SRD;
                    end
                end
            end
            bsa_pkg::S_SRD: n_state = bsa_pkg::S_SCHK;
            bsa_pkg::S_SCHK: begin
                if (u_any) begin
                    n_state = (r_o == r_order) ? bsa_pkg::S_DONE : bsa_pkg::S_SPLIT;
                end else if (last_word && r_o == i_top) begin
                    n_state = bsa_pkg::S_DONE;
                end else begin
                    n_state = bsa_pkg::S_SRD;
                end
            end
            bsa_pkg::S_SPLIT: begin
                if (bsa_pkg::t_ord'(r_o - 1'b1) == r_order) begin
                    n_state = bsa_pkg::S_DONE;
                end
            end
            bsa_pkg::S_FRD: n_state = bsa_pkg::S_FCHK;
            bsa_pkg::S_FCHK: n_state = merge ? bsa_pkg::S_FRD : bsa_pkg::S_DONE;
            bsa_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = bsa_pkg::S_IDLE;
                end
            end
        endcase
        if (i_clear) begin
            n_state = bsa_pkg::S_CLEAR;
        end
    end

    // Datapath and memory control
    always_comb begin
        n_act    = r_act;
        n_order  = r_order;
        n_o      = r_o;
        n_idx    = r_idx;
        n_woff   = r_woff;
        n_status = r_status;
        n_caddr  = r_caddr;
        m_we     = 1'b0;
        m_waddr  = srch_addr;
        m_wdata  = u_word;
        m_raddr  = srch_addr;
        u_bit    = r_idx[bsa_pkg::WORD_LOG-1:0];
        u_op     = bsa_pkg::U_SET;
        unique case (r_state)
            bsa_pkg::S_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_caddr;
                m_wdata = (r_caddr == bsa_pkg::word_base(i_top)) ? bsa_pkg::t_word'(1) : '0;
                n_caddr = bsa_pkg::t_waddr'(r_caddr + 1'b1);
            end
            bsa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = bsa_pkg::t_act'(i_action);
                    n_order  = ord_in;
                    n_o      = ord_in;
                    n_woff   = '0;
                    n_idx    = free_span[bsa_pkg::IDX_W-1:0];
                    n_status = in_range ? bsa_pkg::ST_OK : bsa_pkg::ST_RANGE;
                end
            end
            bsa_pkg::S_SRD: begin
                m_raddr = srch_addr;
            end
            bsa_pkg::S_SCHK: begin
                // take the lowest free block of the word
                u_op  = bsa_pkg::U_CLR;
                u_bit = u_ffs;
                if (u_any) begin
                    m_we  = 1'b1;
                    n_idx = (bsa_pkg::t_idx'(r_woff) << bsa_pkg::WORD_LOG)
                          | bsa_pkg::t_idx'(u_ffs);
                end else if (last_word) begin
                    if (r_o == i_top) begin
                        n_status = bsa_pkg::ST_NOSPACE;
                    end else begin
                        n_o    = bsa_pkg::t_ord'(r_o + 1'b1);
                        n_woff = '0;
                    end
                end else begin
                    n_woff = bsa_pkg::t_woff'(r_woff + 1'b1);
                end
            end
            bsa_pkg::S_SPLIT: begin
                // maps from the requested up to the found order are empty: write the upper buddy alone
                u_op    = bsa_pkg::U_ONE_MATE;
                u_bit   = split_idx[bsa_pkg::WORD_LOG-1:0];
                m_we    = 1'b1;
                m_waddr = bsa_pkg::word_base(bsa_pkg::t_ord'(r_o - 1'b1))
                        + bsa_pkg::t_waddr'(split_idx >> bsa_pkg::WORD_LOG);
                n_o     = bsa_pkg::t_ord'(r_o - 1'b1);
                n_idx   = split_idx;
            end
            bsa_pkg::S_FRD: begin
                m_raddr = free_addr;
            end
            bsa_pkg::S_FCHK: begin
                // block and buddy share a word
                u_op    = merge ? bsa_pkg::U_CLR_MATE : bsa_pkg::U_SET;
                m_we    = 1'b1;
                m_waddr = free_addr;
                if (merge) begin
                    n_idx = r_idx >> 1;
                    n_o   = bsa_pkg::t_ord'(r_o + 1'b1);
                end
            end
            bsa_pkg::S_DONE: begin
                m_raddr = srch_addr;
            end
        endcase
        if (i_clear) begin
            n_caddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsa_pkg::S_CLEAR;
            r_caddr <= '0;
        end else begin
            r_state <= n_state;
            r_caddr <= n_caddr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_order  <= n_order;
        r_o      <= n_o;
        r_idx    <= n_idx;
        r_woff   <= n_woff;
        r_status <= n_status;
    end

    assign o_in_ready   = (r_state == bsa_pkg::S_IDLE);
    assign o_res_valid  = (r_state == bsa_pkg::S_DONE);
    assign o_res.status = r_status;
    assign o_res.first  = (r_act == bsa_pkg::ACT_ALLOC && r_status == bsa_pkg::ST_OK)
                        ? first_span[bsa_pkg::SEG_W-1:0] : '0;

`ifndef ASSERT_OFF
    a_clear_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsa_pkg::S_CLEAR) |-> (r_caddr <= bsa_pkg::t_waddr'(bsa_pkg::N_WORDS - 1)))
        else $error("clearing pass beyond the free map");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsa_pkg::S_SRD || r_state == bsa_pkg::S_SCHK || r_state == bsa_pkg::S_SPLIT
         || r_state == bsa_pkg::S_FRD || r_state == bsa_pkg::S_FCHK) |-> (r_o <= i_top))
        else $error("order walk above top order");

    a_split_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsa_pkg::S_SPLIT) |-> (r_o > r_order))
        else $error("split below requested order");

    a_alloc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_act == bsa_pkg::ACT_ALLOC && r_status == bsa_pkg::ST_OK)
        |-> (r_o == r_order))
        else $error("allocation finished at wrong order");
`endif

endmodule

@@ bench/tb_buddy_segment_allocator_core.sv @@
`timescale 1ns / 1ps

module tb_buddy_segment_allocator_core;

    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 6;
    // Worst case: an order-0 allocate scanning every map word, a long receiver
    // stall and a long sender gap per item, plus clearing passes; taken well
    // over several times.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Cycles to let the sequencer settle before a register write and at the end
    localparam int SETTLE_CYCLES = 200;
    localparam int ITEMS_PER_PHASE = 195;
    localparam int N_PHASES = 9;
    localparam logic [bsa_pkg::APB_AW-1:0] TOP_ORDER_ADDR =
        bsa_pkg::APB_AW'(4 * int'(bsa_pkg::REG_TOP_ORDER));

    // Block handed out by the allocator and not yet returned
    typedef struct {
        int unsigned seg;
        int unsigned ord;
    } t_held_block;

    // Mirror of the per-order free bitmaps; it works out the reply of every
    // request and keeps the replies still owed by the block.
    class buddy_pool;
        bit free_bits[(2 << bsa_pkg::MAX_ORDER) - 1];
        int unsigned top_order;
        bsa_pkg::t_res due_replies[$];
        int unsigned n_requests;
        int unsigned n_grant;
        int unsigned n_nospace;
        int unsigned n_range;
        int unsigned n_free;
        int unsigned n_checked;
        int unsigned n_mismatch;

        function new();
            n_requests = 0;
            n_grant = 0;
            n_nospace = 0;
            n_range = 0;
            n_free = 0;
            n_checked = 0;
            n_mismatch = 0;
            reinit(bsa_pkg::TOP_RESET);
        endfunction

        // First flag of the bitmap of order o
        function int unsigned map_base(int unsigned o);
            return (2 << bsa_pkg::MAX_ORDER) - (2 << (bsa_pkg::MAX_ORDER - o));
        endfunction

        // Clear every map and leave one free block at the (saturated) top order
        function void reinit(int unsigned t);
            top_order = (t > bsa_pkg::MAX_ORDER) ? bsa_pkg::MAX_ORDER : t;
            foreach (free_bits[i]) free_bits[i] = 1'b0;
            free_bits[map_base(top_order)] = 1'b1;
        endfunction

        function bsa_pkg::t_res take_request(bsa_pkg::t_act act, int unsigned ord_in,
                                             int unsigned seg_in);
            bsa_pkg::t_res reply;
            int unsigned ord;
            int unsigned seg;
            int unsigned o;
            int unsigned idx;
            bit found;
            ord = ord_in & 4'hF;
            seg = seg_in & 10'h3FF;
            reply.status = bsa_pkg::ST_OK;
            reply.first = '0;
            found = 1'b0;
            o = ord;
            idx = 0;
            n_requests++;
            if (ord > top_order) begin
                reply.status = bsa_pkg::ST_RANGE;
                n_range++;
            end else if (act == bsa_pkg::ACT_ALLOC) begin
                // Search upward for the lowest free block
                for (int unsigned k = ord; k <= top_order && !found; k++) begin
                    for (int unsigned j = 0; j < (1 << (top_order - k)); j++) begin
                        if (free_bits[map_base(k) + j]) begin
                            found = 1'b1;
                            o = k;
                            idx = j;
                            break;
                        end
                    end
                end
                if (!found) begin
                    reply.status = bsa_pkg::ST_NOSPACE;
                    n_nospace++;
                end else begin
                    // Take it and split down, freeing each upper buddy
                    free_bits[map_base(o) + idx] = 1'b0;
                    while (o > ord) begin
                        o--;
                        idx = idx << 1;
                        free_bits[map_base(o) + (idx ^ 1)] = 1'b1;
                    end
                    reply.first = bsa_pkg::SEG_W'(idx << ord);
                    n_grant++;
                end
            end else begin
                // Wrap the block index to the map width, then merge upward
                idx = (seg >> ord) & ((1 << (top_order - ord)) - 1);
                while (o < top_order && free_bits[map_base(o) + (idx ^ 1)]) begin
                    free_bits[map_base(o) + (idx ^ 1)] = 1'b0;
                    idx = idx >> 1;
                    o++;
                end
                free_bits[map_base(o) + idx] = 1'b1;
                n_free++;
            end
            due_replies.push_back(reply);
            return reply;
        endfunction

        function void match_reply(logic [bsa_pkg::STATUS_W-1:0] status,
                                  logic [bsa_pkg::SEG_W-1:0] first);
            bsa_pkg::t_res want;
            if (due_replies.size() == 0) begin
                $display("%0t: reply with nothing owed: status %0d first_segment %0d",
                         $time, status, first);
                n_mismatch++;
                return;
            end
            want = due_replies.pop_front();
            n_checked++;
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                n_mismatch++;
            end
            if (first !== want.first) begin
                $display("%0t: first_segment mismatch: expected %0d, actual %0d",
                         $time, want.first, first);
                n_mismatch++;
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [bsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // order[3:0], segment[13:4]
    logic                            s_axis_tuser;   // action[0]
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [bsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // first_segment[9:0]
    logic [bsa_pkg::STATUS_W-1:0]    m_axis_tuser;   // status[1:0]
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bsa_pkg::APB_AW-1:0]      paddr;
    logic [bsa_pkg::APB_DW-1:0]      pwdata;
    logic [bsa_pkg::APB_DW-1:0]      prdata;
    logic                            pready;

    buddy_pool pool = new();
    t_held_block held[$];
    int unsigned send_calm = 0;
    int unsigned cycles = 0;
    int unsigned settings_seen = 1;

    buddy_segment_allocator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles, %0d replies still owed",
                     $time, cycles, pool.due_replies.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check every reply the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            pool.match_reply(m_axis_tuser, m_axis_tdata[bsa_pkg::SEG_W-1:0]);
        end
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: stall at random, with calm stretches of steady acceptance
    initial begin
        int unsigned hold_off;
        int unsigned calm;
        hold_off = 0;
        calm = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                hold_off--;
            end else begin
                m_axis_tready <= 1'b1;
                if (calm > 0) begin
                    calm--;
                end else if ($urandom_range(0, 99) < 2) begin
                    calm = $urandom_range(40, 300);
                end else if ($urandom_range(0, 99) < 35) begin
                    hold_off = pick_gap();
                end
            end
        end
    end

    // Present one request after a random gap and hold it until taken.
    // Keep valid high across back-to-back items.
    task automatic send_request(input bsa_pkg::t_act act, input int unsigned ord,
                                input int unsigned seg, output bsa_pkg::t_res reply);
        int unsigned gap;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= bsa_pkg::IN_TDATA_W'({seg[bsa_pkg::SEG_W-1:0],
                                              ord[bsa_pkg::ORD_W-1:0]});
        do @(posedge i_clk); while (!s_axis_tready);
        reply = pool.take_request(act, ord, seg);
    endtask

    task automatic request(input bsa_pkg::t_act act, input int unsigned ord,
                           input int unsigned seg);
        bsa_pkg::t_res reply;
        send_request(act, ord, seg, reply);
    endtask

    // Drop valid and wait until every owed reply is back and the block is quiet
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pool.due_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access cycle; random upper bits must be ignored
    task automatic write_top_order(input int unsigned value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TOP_ORDER_ADDR;
        pwdata <= ($urandom() & 32'hFFFF_FFF0) | (value & 4'hF);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pool.reinit(value & 4'hF);
        held.delete();
        settings_seen++;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Mostly well-formed traffic: allocations and frees of blocks actually
    // held, with the mix swinging between filling and draining the pool.
    // The rest is noise: random action, any order, any segment.
    task automatic random_requests(input int unsigned n);
        t_held_block blk;
        bsa_pkg::t_res reply;
        bsa_pkg::t_act act;
        int unsigned k;
        int unsigned pick;
        int unsigned ord;
        int unsigned seg;
        int unsigned fill_bias;
        int unsigned small_top;
        fill_bias = 60;
        for (int unsigned i = 0; i < n; i++) begin
            if (i % 64 == 0) fill_bias = $urandom_range(25, 80);
            small_top = (pool.top_order < 3) ? pool.top_order : 3;
            pick = $urandom_range(0, 99);
            seg = $urandom_range(0, 1023);
            if (pick < 12) begin
                act = bsa_pkg::t_act'($urandom_range(0, 1));
                ord = $urandom_range(0, 15);
            end else if (held.size() > 0 && $urandom_range(0, 99) >= fill_bias) begin
                k = $urandom_range(0, held.size() - 1);
                blk = held[k];
                held.delete(k);
                act = bsa_pkg::ACT_FREE;
                ord = blk.ord;
                seg = blk.seg;
            end else begin
                act = bsa_pkg::ACT_ALLOC;
                ord = ($urandom_range(0, 99) < 70) ? $urandom_range(0, small_top)
                                                   : $urandom_range(0, pool.top_order);
            end
            send_request(act, ord, seg, reply);
            if (act == bsa_pkg::ACT_ALLOC && reply.status == bsa_pkg::ST_OK) begin
                blk.seg = reply.first;
                blk.ord = ord;
                held.push_back(blk);
            end
        end
    endtask

    initial begin
        int unsigned tops[N_PHASES];
        tops = '{10, 0, 15, 3, 11, 1, 6, 10, 0};
        tops[N_PHASES - 1] = $urandom_range(0, 15);
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset state: one free block of order 10
        request(bsa_pkg::ACT_ALLOC, 10, 0);       // whole pool
        request(bsa_pkg::ACT_ALLOC, 0, 1023);     // nothing left
        request(bsa_pkg::ACT_ALLOC, 11, 0);       // order above top
        request(bsa_pkg::ACT_FREE, 15, 1023);     // order above top on free
        request(bsa_pkg::ACT_FREE, 10, 0);        // merge stops at the top
        request(bsa_pkg::ACT_ALLOC, 0, 0);        // split all the way down
        request(bsa_pkg::ACT_ALLOC, 0, 0);
        request(bsa_pkg::ACT_ALLOC, 3, 0);
        request(bsa_pkg::ACT_ALLOC, 9, 0);
        request(bsa_pkg::ACT_FREE, 0, 1);
        request(bsa_pkg::ACT_FREE, 0, 0);         // merges with its buddy upward
        request(bsa_pkg::ACT_FREE, 3, 13);        // unaligned: low bits dropped
        request(bsa_pkg::ACT_FREE, 3, 8);         // freed twice
        request(bsa_pkg::ACT_FREE, 9, 512);
        request(bsa_pkg::ACT_ALLOC, 10, 0);
        request(bsa_pkg::ACT_FREE, 0, 1023);      // every segment bit set
        request(bsa_pkg::ACT_FREE, 10, 0);
        random_requests(ITEMS_PER_PHASE);
        drain();

        for (int p = 1; p < N_PHASES; p++) begin
            write_top_order(tops[p]);
            if (tops[p] == 3) begin
                request(bsa_pkg::ACT_ALLOC, 3, 0);
                request(bsa_pkg::ACT_ALLOC, 4, 0);       // order above a small top
                request(bsa_pkg::ACT_FREE, 0, 1023);     // segment beyond the pool wraps
                request(bsa_pkg::ACT_FREE, 3, 0);
            end
            random_requests(ITEMS_PER_PHASE);
            drain();
        end

        $display("Ran %0d requests over %0d top_order settings, %0d replies checked",
                 pool.n_requests, settings_seen, pool.n_checked);
        $display("Grants %0d, no space %0d, order above top %0d, frees %0d, mismatches %0d",
                 pool.n_grant, pool.n_nospace, pool.n_range, pool.n_free, pool.n_mismatch);
        if (pool.n_mismatch == 0 && pool.due_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
